FILE: design/nsch_pkg.sv
package nsch_pkg;

    // Node geometry.
    localparam int INDEX_COUNT = 8;
    localparam int GROUP_SIZE  = 8;
    localparam int KEY_DEPTH   = (INDEX_COUNT + 1) * GROUP_SIZE;

    // Field widths of the item ports.
    localparam int CMD_W   = 2;
    localparam int SLOT_W  = 7;
    localparam int KEY_W   = 64;
    localparam int CHILD_W = 7;

    // Derived address and counter widths.
    localparam int IDX_AW = (INDEX_COUNT > 1) ? $clog2(INDEX_COUNT) : 1;
    localparam int GRP_AW = (GROUP_SIZE > 1) ? $clog2(GROUP_SIZE) : 1;
    localparam int KEY_AW = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
    localparam int GCNT_W = $clog2(INDEX_COUNT + 1);
    localparam int CNT_W  = $clog2(GROUP_SIZE + 1);
    localparam int SUM_W  = $clog2(KEY_DEPTH + 1);

    typedef logic [CMD_W-1:0] cmd_t;

    localparam cmd_t CMD_WR_INDEX = 2'd0;
    localparam cmd_t CMD_WR_KEY   = 2'd1;
    localparam cmd_t CMD_SEARCH   = 2'd2;

endpackage

FILE: design/nsch_req_if.sv
interface nsch_req_if;

    logic                                 valid;
    logic                                 ready;
    nsch_pkg::cmd_t                       cmd;
    logic [nsch_pkg::SLOT_W-1:0]          slot;
    logic signed [nsch_pkg::KEY_W-1:0]    entry_value;
    logic signed [nsch_pkg::KEY_W-1:0]    search_key;

    modport source (output valid, output cmd, output slot, output entry_value,
                    output search_key, input ready);
    modport sink   (input valid, input cmd, input slot, input entry_value,
                    input search_key, output ready);

endinterface

FILE: design/nsch_rsp_if.sv
interface nsch_rsp_if;

    logic                           valid;
    logic                           ready;
    logic [nsch_pkg::CHILD_W-1:0]   child_index;

    modport source (output valid, output child_index, input ready);
    modport sink   (input valid, input child_index, output ready);

endinterface

FILE: design/nsch_ram.sv
module nsch_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port, one read port with the read data registered.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/two_level_node_child_search.sv
// Child search for one B+ tree inner node. The node keeps a separator index
// of INDEX_COUNT entries and a key store of (INDEX_COUNT+1)*GROUP_SIZE keys,
// each in its own single-port-read RAM. A write item (index or key) is taken
// while idle and writes one entry; an out-of-range slot and the unused
// command code are dropped without a result. A search item first walks the
// index RAM one entry per cycle, counting the entries that are less than or
// equal to the signed query key to find a group g, then walks the GROUP_SIZE
// keys of group g in the key RAM the same way, and returns g*GROUP_SIZE plus
// that second count as child_index. A search steps through acceptance, one
// read per entry through the single read port of each RAM, and a done state
// that hands the result to the output register once no earlier result is
// still held untaken. The next item is accepted in the cycle after the
// result is loaded, even if the result has not yet been taken; the result
// register then holds until the consumer takes it. Entries that were never
// written read as unknown values. There is no clearing pass after reset.
module two_level_node_child_search (
    input  logic         clk,
    input  logic         rst_n,
    nsch_req_if.sink     req,
    nsch_rsp_if.source   rsp
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_IDX  = 2'd1;
    localparam logic [1:0] ST_KEY  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    // Sequencer state.
    logic [1:0]                    state_reg, state_next;
    logic [nsch_pkg::IDX_AW-1:0]   idx_reg, idx_next;
    logic [nsch_pkg::GRP_AW-1:0]   kpos_reg, kpos_next;
    logic [nsch_pkg::GCNT_W-1:0]   g_reg, g_next;
    logic [nsch_pkg::CNT_W-1:0]    cnt_reg, cnt_next;
    logic                          out_valid_reg, out_valid_next;

    // Payload registers.
    logic signed [nsch_pkg::KEY_W-1:0] key_reg, key_next;
    logic [nsch_pkg::KEY_AW-1:0]       base_reg, base_next;
    logic [nsch_pkg::CHILD_W-1:0]      pend_reg, pend_next;
    logic [nsch_pkg::CHILD_W-1:0]      child_reg, child_next;

    // RAM ports.
    logic                          idx_we;
    logic [nsch_pkg::IDX_AW-1:0]   idx_raddr;
    logic [nsch_pkg::KEY_W-1:0]    idx_rdata;
    logic                          key_we;
    logic [nsch_pkg::KEY_AW-1:0]   key_raddr;
    logic [nsch_pkg::KEY_W-1:0]    key_rdata;

    // Datapath.
    logic                          accept;
    logic                          idx_le;
    logic                          key_le;
    logic                          idx_last;
    logic                          kpos_last;
    logic [nsch_pkg::GCNT_W-1:0]   g_inc;
    logic [nsch_pkg::CNT_W-1:0]    cnt_inc;
    logic [nsch_pkg::KEY_AW-1:0]   base_calc;
    logic [nsch_pkg::SUM_W-1:0]    child_sum;

    assign req.ready = (state_reg == ST_IDLE);
    assign accept    = req.valid && req.ready;

    // Writes only happen while the sequencer is idle, so a search never
    // reads an entry that is being written in the same cycle.
    assign idx_we = accept && (req.cmd == nsch_pkg::CMD_WR_INDEX)
                    && (int'(req.slot) < nsch_pkg::INDEX_COUNT);
    assign key_we = accept && (req.cmd == nsch_pkg::CMD_WR_KEY)
                    && (int'(req.slot) < nsch_pkg::KEY_DEPTH);

    nsch_ram #(
        .WIDTH (nsch_pkg::KEY_W),
        .DEPTH (nsch_pkg::INDEX_COUNT)
    ) u_index_ram (
        .clk   (clk),
        .we    (idx_we),
        .waddr (nsch_pkg::IDX_AW'(req.slot)),
        .wdata (req.entry_value),
        .raddr (idx_raddr),
        .rdata (idx_rdata)
    );

    nsch_ram #(
        .WIDTH (nsch_pkg::KEY_W),
        .DEPTH (nsch_pkg::KEY_DEPTH)
    ) u_key_ram (
        .clk   (clk),
        .we    (key_we),
        .waddr (nsch_pkg::KEY_AW'(req.slot)),
        .wdata (req.entry_value),
        .raddr (key_raddr),
        .rdata (key_rdata)
    );

    // Signed comparisons of the entry read last cycle against the query.
    assign idx_le    = ($signed(idx_rdata) <= key_reg);
    assign key_le    = ($signed(key_rdata) <= key_reg);
    assign idx_last  = (idx_reg == nsch_pkg::IDX_AW'(nsch_pkg::INDEX_COUNT - 1));
    assign kpos_last = (kpos_reg == nsch_pkg::GRP_AW'(nsch_pkg::GROUP_SIZE - 1));
    assign g_inc     = g_reg + nsch_pkg::GCNT_W'(idx_le);
    assign cnt_inc   = cnt_reg + nsch_pkg::CNT_W'(key_le);

    // The group base is a multiply by a small constant.
    assign base_calc = nsch_pkg::KEY_AW'(g_inc)
                       * nsch_pkg::KEY_AW'(nsch_pkg::GROUP_SIZE);
    assign child_sum = nsch_pkg::SUM_W'(base_reg) + nsch_pkg::SUM_W'(cnt_inc);

    // Read addresses are issued in the cycle before the data they return.
    always_comb
    begin
        idx_raddr = '0;
        key_raddr = base_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                idx_raddr = '0;
            end
            ST_IDX:
            begin
                idx_raddr = idx_last ? '0 : idx_reg + 1'b1;
                key_raddr = base_calc;
            end
            ST_KEY:
            begin
                key_raddr = kpos_last ? base_reg
                          : base_reg + nsch_pkg::KEY_AW'(kpos_reg) + 1'b1;
            end
            ST_DONE:
            begin
                key_raddr = base_reg;
            end
            default:
            begin
                idx_raddr = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        kpos_next      = kpos_reg;
        g_next         = g_reg;
        cnt_next       = cnt_reg;
        key_next       = key_reg;
        base_next      = base_reg;
        pend_next      = pend_reg;
        child_next     = child_reg;
        out_valid_next = out_valid_reg;

        if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (req.cmd == nsch_pkg::CMD_SEARCH))
                begin
                    key_next   = req.search_key;
                    idx_next   = '0;
                    g_next     = '0;
                    state_next = ST_IDX;
                end
            end
            ST_IDX:
            begin
                g_next = g_inc;
                if (idx_last)
                begin
                    base_next  = base_calc;
                    kpos_next  = '0;
                    cnt_next   = '0;
                    state_next = ST_KEY;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_KEY:
            begin
                cnt_next = cnt_inc;
                if (kpos_last)
                begin
                    // The child index wraps to the width of the result field.
                    pend_next  = nsch_pkg::CHILD_W'(child_sum);
                    state_next = ST_DONE;
                end
                else
                begin
                    kpos_next = kpos_reg + 1'b1;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    child_next     = pend_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            kpos_reg      <= '0;
            g_reg         <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            kpos_reg      <= kpos_next;
            g_reg         <= g_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        base_reg  <= base_next;
        pend_reg  <= pend_next;
        child_reg <= child_next;
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.child_index = child_reg;

`ifndef SYNTH
    // A search item always starts the index walk in the next cycle.
    a_search_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (req.cmd == nsch_pkg::CMD_SEARCH)) |=> (state_reg == ST_IDX))
        else $error("search item did not start the index walk");

    // The group count never passes the number of index entries.
    a_group_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (int'(g_reg) <= nsch_pkg::INDEX_COUNT))
        else $error("group count out of range");

    // Key reads during the group walk stay inside the key store.
    a_key_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_KEY) |-> (int'(key_raddr) < nsch_pkg::KEY_DEPTH))
        else $error("key read address out of range");

    // A new result is only presented after the sequencer finished a search.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_DONE))
        else $error("result presented without a finished search");

    // A result that is not taken holds its value.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        ($past(out_valid_reg) && !$past(rsp.ready)) |-> $stable(child_reg))
        else $error("pending result changed");
`endif

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps

// Block-level testbench for the B+ tree inner node child search.
//
// The bench keeps its own copy of the node (separator index and grouped key
// store) and updates it for every item that the block accepts. Each accepted
// search pushes the child index that the node copy predicts onto a queue,
// and a checker pops and compares it against every result that the block
// hands over. Write items and dropped items leave nothing on the queue.
//
// The node is always fully loaded before the first search, so the block never
// reads an entry that was never written. Most of the random traffic runs
// against sorted node images with query keys placed on and next to stored
// values, where the two-level count is most likely to go wrong. The rest
// scrambles the ordering, hits the key extremes, or sends items that the
// block must ignore.
module testbench;

    // Command code that the block must ignore.
    localparam nsch_pkg::cmd_t CMD_NONE = 2'd3;

    localparam logic signed [nsch_pkg::KEY_W-1:0] KEY_MIN =
        {1'b1, {(nsch_pkg::KEY_W-1){1'b0}}};
    localparam logic signed [nsch_pkg::KEY_W-1:0] KEY_MAX =
        {1'b0, {(nsch_pkg::KEY_W-1){1'b1}}};

    // Length of one search in the block, from acceptance to result.
    localparam int SEARCH_CYCLES = nsch_pkg::INDEX_COUNT + nsch_pkg::GROUP_SIZE + 2;
    // Quiet cycles allowed at the end, after the last expected result.
    localparam int TAIL_CYCLES   = 2 * SEARCH_CYCLES;
    // Cycles without any handshake on either channel before the run is
    // declared hung. The slowest correct stretch is a sender gap, a whole
    // search and a receiver stall.
    localparam int QUIET_LIMIT   = 1000;

    typedef struct {
        logic signed [nsch_pkg::KEY_W-1:0] key;
        logic [nsch_pkg::CHILD_W-1:0]      child;
    } child_expect_t;

    logic clk;
    logic rst_n;

    nsch_req_if req_ch ();
    nsch_rsp_if rsp_ch ();

    two_level_node_child_search i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Node copy that the predictions are computed from.
    logic signed [nsch_pkg::KEY_W-1:0] sep_mem [nsch_pkg::INDEX_COUNT];
    logic signed [nsch_pkg::KEY_W-1:0] key_mem [nsch_pkg::KEY_DEPTH];

    // Child indexes still owed by the block, oldest first.
    child_expect_t pending_children [$];

    int n_errors     = 0;
    int n_searches   = 0;
    int n_writes     = 0;
    int n_dropped    = 0;
    int n_checked    = 0;
    int n_images     = 0;
    int quiet_cycles = 0;
    int stall_left   = 0;

    // Random idling on the two sides; the tail of the run turns both off.
    bit req_idle_on = 1'b1;
    bit rsp_idle_on = 1'b1;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Prints one line per mismatch and counts it.
    task automatic flag_error(input string what);
        n_errors++;
        $display("MISMATCH at %0t: %s", $time, what);
    endtask

    function automatic logic [nsch_pkg::KEY_W-1:0] any_word();
        return {$urandom, $urandom};
    endfunction

    // Applies one accepted item to the node copy. Returns 1 when the item is
    // a search, with the predicted child index: the number of separators not
    // above the key picks the group, and the number of keys of that group
    // not above the key is added to the start of the group. All entries are
    // counted, so an unsorted node is predicted the same way as the block
    // should treat it.
    function automatic bit node_apply(input nsch_pkg::cmd_t c,
                                      input logic [nsch_pkg::SLOT_W-1:0] s,
                                      input logic signed [nsch_pkg::KEY_W-1:0] v,
                                      input logic signed [nsch_pkg::KEY_W-1:0] k,
                                      output logic [nsch_pkg::CHILD_W-1:0] child);
        int grp;
        int hits;
        grp   = 0;
        hits  = 0;
        child = '0;
        if (c == nsch_pkg::CMD_WR_INDEX)
        begin
            if (s < nsch_pkg::INDEX_COUNT)
                sep_mem[s] = v;
            return 1'b0;
        end
        if (c == nsch_pkg::CMD_WR_KEY)
        begin
            if (s < nsch_pkg::KEY_DEPTH)
                key_mem[s] = v;
            return 1'b0;
        end
        if (c != nsch_pkg::CMD_SEARCH)
            return 1'b0;
        for (int i = 0; i < nsch_pkg::INDEX_COUNT; i++)
            if (sep_mem[i] <= k)
                grp++;
        for (int i = 0; i < nsch_pkg::GROUP_SIZE; i++)
            if (key_mem[grp * nsch_pkg::GROUP_SIZE + i] <= k)
                hits++;
        child = nsch_pkg::CHILD_W'(grp * nsch_pkg::GROUP_SIZE + hits);
        return 1'b1;
    endfunction

    // Sends one item. It is entered and left just after a falling edge, so
    // back-to-back calls keep valid high without a bubble. The node copy is
    // updated at the rising edge where the item is accepted.
    task automatic send_item(input nsch_pkg::cmd_t c,
                             input logic [nsch_pkg::SLOT_W-1:0] s,
                             input logic signed [nsch_pkg::KEY_W-1:0] v,
                             input logic signed [nsch_pkg::KEY_W-1:0] k);
        child_expect_t                entry;
        logic [nsch_pkg::CHILD_W-1:0] child;
        bit                           dropped;
        dropped = (c == CMD_NONE)
                  || (c == nsch_pkg::CMD_WR_INDEX && s >= nsch_pkg::INDEX_COUNT)
                  || (c == nsch_pkg::CMD_WR_KEY && s >= nsch_pkg::KEY_DEPTH);
        if (req_idle_on && $urandom_range(0, 5) == 0)
            repeat ($urandom_range(1, 12)) @(negedge clk);
        req_ch.cmd         = c;
        req_ch.slot        = s;
        req_ch.entry_value = v;
        req_ch.search_key  = k;
        req_ch.valid       = 1'b1;
        do @(posedge clk); while (req_ch.ready !== 1'b1);
        if (node_apply(c, s, v, k, child))
        begin
            entry.key   = k;
            entry.child = child;
            pending_children.push_back(entry);
            n_searches++;
        end
        else if (dropped)
            n_dropped++;
        else
            n_writes++;
        @(negedge clk);
        req_ch.valid = 1'b0;
    endtask

    // The fields that a command does not use still carry random bits.
    task automatic write_sep(input int idx, input logic signed [nsch_pkg::KEY_W-1:0] v);
        send_item(nsch_pkg::CMD_WR_INDEX, nsch_pkg::SLOT_W'(idx), v, any_word());
    endtask

    task automatic write_key(input int idx, input logic signed [nsch_pkg::KEY_W-1:0] v);
        send_item(nsch_pkg::CMD_WR_KEY, nsch_pkg::SLOT_W'(idx), v, any_word());
    endtask

    task automatic search(input logic signed [nsch_pkg::KEY_W-1:0] k);
        send_item(nsch_pkg::CMD_SEARCH,
                  nsch_pkg::SLOT_W'($urandom_range(0, 2**nsch_pkg::SLOT_W - 1)),
                  any_word(), k);
    endtask

    // Holds the sender off until every owed result has been taken.
    task automatic wait_drain();
        while (pending_children.size() != 0)
            @(negedge clk);
    endtask

    // Loads a complete, sorted node image. Values are built in a biased
    // (sign-flipped) domain so that an ascending unsigned walk is an
    // ascending signed walk. Each separator sits just past the last key of
    // its group; half the time the next group starts on the separator value
    // itself, which is how a real tree usually places them.
    task automatic load_node(input int spread);
        logic [63:0] stride_max;
        logic [63:0] walk;
        bit          hold;
        stride_max = (spread == 0) ? 64'd3 : (spread == 1) ? 64'd65536 : 64'd1 << 56;
        walk       = any_word() % (64'hFFFF_FFFF_FFFF_FFFF - 81 * stride_max);
        hold       = 1'b0;
        for (int g = 0; g <= nsch_pkg::INDEX_COUNT; g++)
        begin
            for (int j = 0; j < nsch_pkg::GROUP_SIZE; j++)
            begin
                if (!hold)
                    walk = walk + any_word() % stride_max + 1;
                hold = 1'b0;
                write_key(g * nsch_pkg::GROUP_SIZE + j, walk ^ 64'h8000_0000_0000_0000);
            end
            if (g < nsch_pkg::INDEX_COUNT)
            begin
                walk = walk + any_word() % stride_max + 1;
                hold = 1'($urandom_range(0, 1));
                write_sep(g, walk ^ 64'h8000_0000_0000_0000);
            end
        end
        n_images++;
    endtask

    // Query key aimed at the interesting spots of the current node: on or
    // next to a stored separator or key, at the extremes, or anywhere.
    function automatic logic signed [nsch_pkg::KEY_W-1:0] probe_key();
        logic signed [nsch_pkg::KEY_W-1:0] k;
        int sel;
        int nudge;
        sel   = $urandom_range(0, 9);
        nudge = int'($urandom_range(0, 2)) - 1;
        if (sel == 0)
            k = any_word();
        else if (sel == 1)
            k = $urandom_range(0, 1) ? KEY_MAX : KEY_MIN;
        else if (sel < 5)
            k = sep_mem[$urandom_range(0, nsch_pkg::INDEX_COUNT - 1)] + nudge;
        else
            k = key_mem[$urandom_range(0, nsch_pkg::KEY_DEPTH - 1)] + nudge;
        return k;
    endfunction

    // One random item on top of the loaded node. Searches dominate; some
    // in-range writes break the ordering, and a few items must be ignored.
    task automatic random_item();
        int sel;
        sel = $urandom_range(0, 19);
        if (sel < 13)
            search(probe_key());
        else if (sel < 15)
            search(any_word());
        else if (sel < 16)
            write_sep($urandom_range(0, nsch_pkg::INDEX_COUNT - 1), probe_key());
        else if (sel < 18)
            write_key($urandom_range(0, nsch_pkg::KEY_DEPTH - 1),
                      $urandom_range(0, 3) == 0 ? any_word() : probe_key());
        else if (sel < 19)
            send_item(CMD_NONE,
                      nsch_pkg::SLOT_W'($urandom_range(0, 2**nsch_pkg::SLOT_W - 1)),
                      any_word(), any_word());
        else
            send_item($urandom_range(0, 1) ? nsch_pkg::CMD_WR_INDEX : nsch_pkg::CMD_WR_KEY,
                      nsch_pkg::SLOT_W'($urandom_range(nsch_pkg::INDEX_COUNT,
                                                       2**nsch_pkg::SLOT_W - 1)),
                      any_word(), any_word());
    endtask

    // ---------------------------------------------------------------- tests

    // Every entry is written before the first search.
    task automatic test_load_node();
        load_node(1);
        wait_drain();
    endtask

    // The smallest and largest keys, both stored and queried. A query at the
    // largest key must land past the last key of the last group.
    task automatic test_extreme_entries();
        write_key(0, KEY_MIN);
        write_key(nsch_pkg::KEY_DEPTH - 1, KEY_MAX);
        search(KEY_MIN);
        search(KEY_MAX);
        search(KEY_MIN + 1);
        search(KEY_MAX - 1);
        wait_drain();
    endtask

    // Queries just below, on and just above separators, which decide the
    // group, and one query exactly on a stored key.
    task automatic test_boundary_queries();
        logic signed [nsch_pkg::KEY_W-1:0] s0;
        logic signed [nsch_pkg::KEY_W-1:0] s1;
        s0 = sep_mem[0];
        s1 = sep_mem[nsch_pkg::INDEX_COUNT - 1];
        search(s0 - 1);
        search(s0);
        search(s0 + 1);
        search(s1 - 1);
        search(s1);
        search(s1 + 1);
        search(key_mem[nsch_pkg::GROUP_SIZE + nsch_pkg::GROUP_SIZE / 2]);
        wait_drain();
    endtask

    // The unused command and writes to slots past the end of either store
    // must change nothing; the searches after them show the node intact.
    task automatic test_ignored_items();
        send_item(CMD_NONE, nsch_pkg::SLOT_W'(0), KEY_MIN, KEY_MAX);
        write_sep(nsch_pkg::INDEX_COUNT, KEY_MAX);
        write_sep(2**nsch_pkg::SLOT_W - 1, KEY_MIN);
        write_key(nsch_pkg::KEY_DEPTH, KEY_MIN);
        write_key(2**nsch_pkg::SLOT_W - 1, KEY_MAX);
        search('0);
        search(-1);
        wait_drain();
    endtask

    // An out-of-order separator and key: every entry is still counted.
    task automatic test_unsorted_entries();
        write_sep(nsch_pkg::INDEX_COUNT / 2, KEY_MAX);
        write_key(nsch_pkg::GROUP_SIZE + 1, KEY_MIN);
        search(sep_mem[nsch_pkg::INDEX_COUNT - 1]);
        search(key_mem[nsch_pkg::GROUP_SIZE]);
        search(KEY_MAX);
        wait_drain();
    endtask

    // Node images of randomly chosen spreads with random traffic on top. Some images
    // run with no idling on one side or the other, and once in the middle
    // the sender waits for the block to drain completely.
    task automatic test_random_traffic();
        int goal;
        int image_no;
        goal     = n_searches + n_writes + 1250;
        image_no = 0;
        while (n_searches + n_writes < goal)
        begin
            req_idle_on = (image_no % 3 != 1);
            rsp_idle_on = (image_no % 4 != 2);
            load_node($urandom_range(0, 2));
            repeat (120)
                random_item();
            if (image_no == 3)
                wait_drain();
            image_no++;
        end
    endtask

    // The last stretch runs at full rate on both sides.
    task automatic test_quiet_tail();
        req_idle_on = 1'b0;
        rsp_idle_on = 1'b0;
        load_node($urandom_range(0, 2));
        repeat (265)
            random_item();
    endtask

    // ------------------------------------------------------------ processes

    // Receiver: ready drops in random bursts while idling is on.
    initial
    begin
        rsp_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                rsp_ch.ready = 1'b0;
                stall_left--;
            end
            else
            begin
                rsp_ch.ready = 1'b1;
                if (rsp_idle_on && $urandom_range(0, 7) == 0)
                    stall_left = $urandom_range(1, 12);
            end
        end
    end

    // Result checker: every taken result must match the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
        begin
            if (pending_children.size() == 0)
                flag_error($sformatf("child_index %0d with no search pending",
                                     rsp_ch.child_index));
            else
            begin
                if (rsp_ch.child_index !== pending_children[0].child)
                    flag_error($sformatf("key %0d: child_index %0d, predicted %0d",
                                         pending_children[0].key, rsp_ch.child_index,
                                         pending_children[0].child));
                void'(pending_children.pop_front());
                n_checked++;
            end
        end
    end

    // Watchdog: a run with no handshake on either channel for too long hangs.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("Timeout: %0d cycles without a handshake, %0d results owed",
                         quiet_cycles, pending_children.size());
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // Main sequence.
    initial
    begin
        rst_n              = 1'b0;
        req_ch.valid       = 1'b0;
        req_ch.cmd         = CMD_NONE;
        req_ch.slot        = '0;
        req_ch.entry_value = '0;
        req_ch.search_key  = '0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        test_load_node();
        test_extreme_entries();
        test_boundary_queries();
        test_ignored_items();
        test_unsorted_entries();
        test_random_traffic();
        test_quiet_tail();

        wait_drain();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (pending_children.size() != 0)
            flag_error($sformatf("%0d results never arrived", pending_children.size()));

        $display("Ran %0d searches (%0d results checked) over %0d node images,",
                 n_searches, n_checked, n_images);
        $display("with %0d entry writes and %0d ignored items; %0d mismatches.",
                 n_writes, n_dropped, n_errors);
        if (n_errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

FILE: two_level_node_child_search.f
design/nsch_pkg.sv
design/nsch_req_if.sv
design/nsch_rsp_if.sv
design/nsch_ram.sv
design/two_level_node_child_search.sv
test/testbench.sv
